[hw/rtl/pcl_pkg.sv]
// polygon plane clipper package: widths, register indexes and sequencer states
// no dependencies
package pcl_pkg;

  localparam int COORD_W   = 32;
  localparam int NORM_W    = 16;
  localparam int LIMIT_W   = 32;
  localparam int DIST_W    = 50;
  localparam int FRAC_W    = 16;
  localparam int MUL_A_W   = COORD_W + 1;
  localparam int MUL_B_W   = FRAC_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int OCNT_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int LIMIT_SH  = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_LIMIT = 3'd3;

  localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = 16'sd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_EDGE,
    ST_EMIT_A,
    ST_DIV,
    ST_INTERP,
    ST_EMIT_X,
    ST_MARK,
    ST_FINISH
  } pcl_state_e;

endpackage

[hw/rtl/pcl_vertex_if.sv]
// input vertex channel: valid/ready request with one polygon vertex
// depends on pcl_pkg
interface pcl_vertex_if
  import pcl_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] vertex_z;
  logic                      last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

[hw/rtl/pcl_result_if.sv]
// output channel: valid/ready request with one clipped vertex or end marker
// depends on pcl_pkg
interface pcl_result_if
  import pcl_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      has_vertex;
  logic                      poly_done;
  logic [OCNT_W-1:0]         vertex_count;

  modport source (output valid, out_x, out_y, out_z, has_vertex, poly_done, vertex_count,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, has_vertex, poly_done, vertex_count,
                  output ready);
endinterface

[hw/rtl/polygon_plane_clipper.sv]
// polygon plane clipper top level: one-plane polygon clip on a shared multiplier
// depends on pcl_pkg, pcl_vertex_if, pcl_result_if
// sequence: plane distance accumulated over x, y and z, then an edge decision, then for
//   each crossing a radix-2 divide and an interpolation of each axis; every result waits
//   for the output to be free, and a final vertex also clips its closing edge
// throughput: one vertex at a time, set by the shared 33x17 multiplier and radix-2 divider
// reset: async active low, returns to idle with the plane at its reset values
module polygon_plane_clipper
  import pcl_pkg::*;
#(
  parameter int MAX_VERTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pcl_vertex_if.sink           in_vertex,
  pcl_result_if.source         out_vertex
);

  localparam int CNT_W = $clog2(MAX_VERTS);
  localparam logic [CNT_W:0] CAP = (CNT_W + 1)'(MAX_VERTS - 1);

  pcl_state_e state_q, state_d;

  logic signed [NORM_W-1:0]  normal_q [3];
  logic signed [LIMIT_W-1:0] limit_q;

  logic signed [COORD_W-1:0] cur_q   [3];
  logic signed [COORD_W-1:0] prev_q  [3];
  logic signed [COORD_W-1:0] first_q [3];
  logic signed [COORD_W-1:0] px_q    [3];
  logic signed [DIST_W-1:0]  acc_q, prev_d_q, first_d_q;
  logic                      last_q, closing_q, emit_x_q, have_first_q;
  logic [CNT_W-1:0]          count_q;
  logic [3:0]                seq_q;
  logic [DIST_W+1:0]         rem_q;
  logic [DIST_W:0]           den_q;
  logic [FRAC_W-1:0]         quo_q;

  logic                      ovalid_q;
  logic signed [COORD_W-1:0] ox_q, oy_q, oz_q;
  logic                      ohas_q, odone_q;
  logic [CNT_W-1:0]          ocnt_q;

  // edge operands
  logic signed [COORD_W-1:0] a_vec [3];
  logic signed [DIST_W-1:0]  da, db;
  logic [DIST_W-1:0]         mag_a, mag_b;
  logic                      emit_a, crossing, emit_x, under_cap;
  logic [CNT_W:0]            cnt_after_a;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_vec[i] = closing_q ? cur_q[i] : prev_q[i];
    end
    da          = closing_q ? acc_q : prev_d_q;
    db          = closing_q ? first_d_q : acc_q;
    mag_a       = da[DIST_W-1] ? DIST_W'(-da) : DIST_W'(da);
    mag_b       = db[DIST_W-1] ? DIST_W'(-db) : DIST_W'(db);
    under_cap   = {1'b0, count_q} < CAP;
    emit_a      = (da <= 0);
    crossing    = (da < 0 && db > 0) || (da > 0 && db < 0);
    cnt_after_a = {1'b0, count_q} + (CNT_W + 1)'(emit_a);
    emit_x      = crossing && (cnt_after_a < CAP);
  end

  // shared multiplier
  logic [1:0]                ax;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [COORD_W-1:0] b_coord;

  assign ax = seq_q[1:0];

  always_comb begin
    b_coord = closing_q ? first_q[ax] : cur_q[ax];
    if (state_q == ST_INTERP) begin
      mul_a = MUL_A_W'({b_coord[COORD_W-1], b_coord})
            - MUL_A_W'({a_vec[ax][COORD_W-1], a_vec[ax]});
      mul_b = MUL_B_W'({1'b0, quo_q});
    end else begin
      mul_a = MUL_A_W'(cur_q[ax]);
      mul_b = MUL_B_W'(normal_q[ax]);
    end
    prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // divider step
  logic [DIST_W+1:0] rem_sh;
  logic              rem_ge;
  assign rem_sh = {rem_q[DIST_W:0], 1'b0};
  assign rem_ge = rem_sh >= (DIST_W + 2)'(den_q);

  logic out_free;
  assign out_free        = !ovalid_q || out_vertex.ready;
  assign in_vertex.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_vertex.valid) state_d = ST_DIST;
      ST_DIST: begin
        if (ax == 2'd2) begin
          if (have_first_q) state_d = ST_EDGE;
          else if (last_q)  state_d = ST_EDGE;
          else              state_d = ST_FINISH;
        end
      end
      ST_EDGE: begin
        if (under_cap && emit_a)      state_d = ST_EMIT_A;
        else if (under_cap && emit_x) state_d = ST_DIV;
        else if (closing_q)           state_d = ST_MARK;
        else if (last_q)              state_d = ST_EDGE;
        else                          state_d = ST_FINISH;
      end
      ST_EMIT_A: begin
        if (out_free) begin
          if (emit_x_q)       state_d = ST_DIV;
          else if (closing_q) state_d = ST_FINISH;
          else if (last_q)    state_d = ST_EDGE;
          else                state_d = ST_FINISH;
        end
      end
      ST_DIV:    if (seq_q == 4'd15) state_d = ST_INTERP;
      ST_INTERP: if (ax == 2'd2) state_d = ST_EMIT_X;
      ST_EMIT_X: begin
        if (out_free) begin
          if (!closing_q && last_q) state_d = ST_EDGE;
          else                      state_d = ST_FINISH;
        end
      end
      ST_MARK:   if (out_free) state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= NORMAL_Z_RESET;
      limit_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NORMAL_X:    normal_q[0] <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Y:    normal_q[1] <= cfg_data_i[NORM_W-1:0];
        CFG_NORMAL_Z:    normal_q[2] <= cfg_data_i[NORM_W-1:0];
        CFG_PLANE_LIMIT: limit_q     <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic load_a, load_x, load_m;
  assign load_a = (state_q == ST_EMIT_A) && out_free;
  assign load_x = (state_q == ST_EMIT_X) && out_free;
  assign load_m = (state_q == ST_MARK) && out_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= '0;
      closing_q    <= 1'b0;
      have_first_q <= 1'b0;
      count_q      <= '0;
      ovalid_q     <= 1'b0;
    end else begin
      if (load_a || load_x || load_m) ovalid_q <= 1'b1;
      else if (out_vertex.ready)      ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          seq_q     <= '0;
          closing_q <= 1'b0;
        end
        ST_DIST: begin
          seq_q <= (ax == 2'd2) ? 4'd0 : seq_q + 4'd1;
          if (ax == 2'd2 && !have_first_q) begin
            have_first_q <= 1'b1;
            count_q      <= '0;
            closing_q    <= last_q;
          end
        end
        ST_EDGE: begin
          seq_q <= '0;
          if (!(under_cap && (emit_a || emit_x)) && !closing_q && last_q) closing_q <= 1'b1;
        end
        ST_EMIT_A: begin
          if (out_free) begin
            count_q <= count_q + 1'b1;
            if (!emit_x_q && !closing_q && last_q) closing_q <= 1'b1;
          end
        end
        ST_DIV:    seq_q <= seq_q + 4'd1;
        ST_INTERP: seq_q <= (ax == 2'd2) ? 4'd0 : seq_q + 4'd1;
        ST_EMIT_X: begin
          if (out_free) begin
            count_q <= count_q + 1'b1;
            if (!closing_q && last_q) closing_q <= 1'b1;
          end
        end
        ST_MARK: ;
        ST_FINISH: begin
          if (last_q) begin
            have_first_q <= 1'b0;
            count_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_vertex.valid) begin
          cur_q[0] <= in_vertex.vertex_x;
          cur_q[1] <= in_vertex.vertex_y;
          cur_q[2] <= in_vertex.vertex_z;
          last_q   <= in_vertex.last_vertex;
          acc_q    <= -DIST_W'({{(DIST_W-LIMIT_W-LIMIT_SH){limit_q[LIMIT_W-1]}}, limit_q,
                                {LIMIT_SH{1'b0}}});
        end
      end
      ST_DIST: begin
        acc_q <= acc_q + DIST_W'(prod);
      end
      ST_EDGE: begin
        emit_x_q <= emit_x;
        rem_q    <= (DIST_W + 2)'(mag_a);
        den_q    <= (DIST_W + 1)'(mag_a) + (DIST_W + 1)'(mag_b);
        quo_q    <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_ge ? rem_sh - (DIST_W + 2)'(den_q) : rem_sh;
        quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
      end
      ST_INTERP: begin
        px_q[ax] <= a_vec[ax] + prod[COORD_W+FRAC_W-1:FRAC_W];
      end
      ST_FINISH: begin
        prev_q[0] <= cur_q[0];
        prev_q[1] <= cur_q[1];
        prev_q[2] <= cur_q[2];
        prev_d_q  <= acc_q;
      end
      default: ;
    endcase
    if (state_q == ST_DIST && ax == 2'd2 && !have_first_q) begin
      first_q[0] <= cur_q[0];
      first_q[1] <= cur_q[1];
      first_q[2] <= cur_q[2];
      first_d_q  <= acc_q + DIST_W'(prod);
    end
    if (load_a) begin
      ox_q    <= a_vec[0];
      oy_q    <= a_vec[1];
      oz_q    <= a_vec[2];
      ohas_q  <= 1'b1;
      odone_q <= closing_q && !emit_x_q;
      ocnt_q  <= count_q + 1'b1;
    end else if (load_x) begin
      ox_q    <= px_q[0];
      oy_q    <= px_q[1];
      oz_q    <= px_q[2];
      ohas_q  <= 1'b1;
      odone_q <= closing_q;
      ocnt_q  <= count_q + 1'b1;
    end else if (load_m) begin
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      ohas_q  <= 1'b0;
      odone_q <= 1'b1;
      ocnt_q  <= count_q;
    end
  end

  logic [CNT_W+OCNT_W-1:0] ocnt_ext;
  assign ocnt_ext = (CNT_W + OCNT_W)'(ocnt_q);

  assign out_vertex.valid        = ovalid_q;
  assign out_vertex.out_x        = ox_q;
  assign out_vertex.out_y        = oy_q;
  assign out_vertex.out_z        = oz_q;
  assign out_vertex.has_vertex   = ohas_q;
  assign out_vertex.poly_done    = odone_q;
  assign out_vertex.vertex_count = ocnt_ext[OCNT_W-1:0];

endmodule

[hw/rtl/pcl_checker.sv]
// port-level checks for the polygon plane clipper, bound to the top level
// depends on pcl_pkg and polygon_plane_clipper
module pcl_checker
  import pcl_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input logic signed [COORD_W-1:0] out_z,
  input logic                      has_vertex,
  input logic                      poly_done
);

  // one vertex in flight at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("vertex request taken while busy");

  // an end marker only closes a polygon
  a_marker_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !has_vertex |-> poly_done)
    else $error("end marker without poly_done");

  // end marker carries zero coordinates
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !has_vertex |-> out_x == 0 && out_y == 0 && out_z == 0)
    else $error("end marker with coordinates");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(poly_done))
    else $error("stalled result changed");

endmodule

bind polygon_plane_clipper pcl_checker u_pcl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_vertex.valid),
  .in_ready   (in_vertex.ready),
  .out_valid  (out_vertex.valid),
  .out_ready  (out_vertex.ready),
  .out_x      (out_vertex.out_x),
  .out_y      (out_vertex.out_y),
  .out_z      (out_vertex.out_z),
  .has_vertex (out_vertex.has_vertex),
  .poly_done  (out_vertex.poly_done)
);

[tb/sv/tb_polygon_plane_clipper.sv]
`timescale 1ns / 100ps
// testbench for polygon_plane_clipper: directed table then random polygons, checked
// against an in-bench clip predictor; depends on pcl_pkg, pcl_vertex_if, pcl_result_if
module tb_polygon_plane_clipper;
  import pcl_pkg::*;

  localparam int MAX_VERTS   = 32;
  localparam int CLIP_CAP    = MAX_VERTS - 1;
  localparam int RAND_ITEMS  = 150;
  localparam int LONG_POLY   = 34;
  localparam int IDLE_PAUSE  = 64;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

  typedef longint pt_t [3];

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               has_vertex;
    logic               done;
    logic [OCNT_W-1:0]  count;
  } clip_vtx_t;

  typedef enum logic {ROW_CFG, ROW_VTX} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]   data;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               last;
    bit                 typed;
    clip_vtx_t          want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  pcl_vertex_if vtx_if ();
  pcl_result_if res_if ();

  polygon_plane_clipper #(
    .MAX_VERTS(MAX_VERTS)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_vertex (vtx_if),
    .out_vertex(res_if)
  );

  // plane and clip state of the predictor
  longint plane_nx  = 0;
  longint plane_ny  = 0;
  longint plane_nz  = 16384;
  longint plane_lim = 0;
  pt_t    prev_pt   = '{0, 0, 0};
  pt_t    first_pt  = '{0, 0, 0};
  longint prev_dist = 0;
  longint first_dist = 0;
  int     n_emitted = 0;
  bit     poly_open = 0;

  clip_vtx_t pending_vertices[$];
  stim_row_t directed_rows[$];
  int        bad_results = 0;
  int        tx_idle_pct = 33;
  int        rx_idle_pct = 76;
  int        cycle_cnt   = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic pt_t to_pt(logic [COORD_W-1:0] x, y, z);
    pt_t p;
    p[0] = longint'($signed(x));
    p[1] = longint'($signed(y));
    p[2] = longint'($signed(z));
    return p;
  endfunction

  function automatic longint plane_distance(pt_t p);
    return p[0] * plane_nx + p[1] * plane_ny + p[2] * plane_nz - (plane_lim <<< LIMIT_SH);
  endfunction

  function automatic clip_vtx_t make_vtx(pt_t p, logic hv);
    clip_vtx_t v;
    v.x          = p[0][COORD_W-1:0];
    v.y          = p[1][COORD_W-1:0];
    v.z          = p[2][COORD_W-1:0];
    v.has_vertex = hv;
    v.done       = 1'b0;
    v.count      = n_emitted[OCNT_W-1:0];
    return v;
  endfunction

  function automatic clip_vtx_t want_vtx(logic [COORD_W-1:0] x, y, z, logic hv,
                                         logic [OCNT_W-1:0] cnt);
    clip_vtx_t v;
    v.x          = x;
    v.y          = y;
    v.z          = z;
    v.has_vertex = hv;
    v.done       = 1'b1;
    v.count      = cnt;
    return v;
  endfunction

  task automatic clip_edge(input pt_t a, input longint da, input pt_t b, input longint db,
                           ref clip_vtx_t res[$]);
    longint     ma;
    longint     mb;
    longint     frac;
    logic [127:0] num_w;
    logic [127:0] den_w;
    logic [127:0] quo_w;
    pt_t        p;
    if (n_emitted >= CLIP_CAP) return;
    if (da <= 0) begin
      n_emitted++;
      res.push_back(make_vtx(a, 1'b1));
    end
    if (n_emitted < CLIP_CAP && ((da < 0 && db > 0) || (da > 0 && db < 0))) begin
      ma    = (da < 0) ? -da : da;
      mb    = (db < 0) ? -db : db;
      num_w = {64'd0, ma} << FRAC_W;
      den_w = {64'd0, ma + mb};
      quo_w = num_w / den_w;
      frac  = longint'(quo_w[63:0]);
      for (int j = 0; j < 3; j++) begin
        p[j] = a[j] + ((frac * (b[j] - a[j])) >>> FRAC_W);
      end
      n_emitted++;
      res.push_back(make_vtx(p, 1'b1));
    end
  endtask

  task automatic clip_step(input logic [COORD_W-1:0] x, y, z, input logic last,
                           ref clip_vtx_t res[$]);
    pt_t       cur;
    pt_t       zero_pt;
    longint    dc;
    int        start;
    clip_vtx_t tail;
    cur     = to_pt(x, y, z);
    zero_pt = '{0, 0, 0};
    dc      = plane_distance(cur);
    if (!poly_open) begin
      first_pt   = cur;
      first_dist = dc;
      n_emitted  = 0;
      poly_open  = 1'b1;
    end else begin
      clip_edge(prev_pt, prev_dist, cur, dc, res);
    end
    prev_pt   = cur;
    prev_dist = dc;
    if (last) begin
      start = res.size();
      clip_edge(cur, dc, first_pt, first_dist, res);
      if (res.size() == start) res.push_back(make_vtx(zero_pt, 1'b0));
      tail      = res.pop_back();
      tail.done = 1'b1;
      res.push_back(tail);
      poly_open = 1'b0;
      n_emitted = 0;
    end
  endtask

  task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_NORMAL_X:    plane_nx  = longint'($signed(data[NORM_W-1:0]));
      CFG_NORMAL_Y:    plane_ny  = longint'($signed(data[NORM_W-1:0]));
      CFG_NORMAL_Z:    plane_nz  = longint'($signed(data[NORM_W-1:0]));
      CFG_PLANE_LIMIT: plane_lim = longint'($signed(data[LIMIT_W-1:0]));
      default: ;
    endcase
  endtask

  // drain, then give the block time to finish any step with no result
  task automatic wait_idle();
    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic send_vertex(logic [COORD_W-1:0] x, y, z, logic last, bit typed,
                             clip_vtx_t want);
    clip_vtx_t step_res[$];
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk_i);
    vtx_if.valid       = 1'b1;
    vtx_if.vertex_x    = x;
    vtx_if.vertex_y    = y;
    vtx_if.vertex_z    = z;
    vtx_if.last_vertex = last;
    do @(posedge clk_i); while (vtx_if.ready !== 1'b1);
    clip_step(x, y, z, last, step_res);
    if (typed) pending_vertices.push_back(want);
    else foreach (step_res[i]) pending_vertices.push_back(step_res[i]);
    @(negedge clk_i);
    vtx_if.valid = 1'b0;
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    r.x     = '0;
    r.y     = '0;
    r.z     = '0;
    r.last  = 1'b0;
    r.typed = 1'b0;
    r.want  = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_vtx(logic [COORD_W-1:0] x, y, z, logic last, bit typed = 0,
                         clip_vtx_t want = '0);
    stim_row_t r;
    r.kind  = ROW_VTX;
    r.idx   = '0;
    r.data  = '0;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(bit narrow);
    if (!narrow) begin
      case ($urandom_range(15))
        0: return $urandom();
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0000;
        default: ;
      endcase
    end
    return int'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  task automatic rand_plane();
    logic [31:0] noise;
    int          nv;
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(1) == 0) begin
        noise = $urandom();
        case ($urandom_range(5))
          0:       nv = 16384;
          1:       nv = -16384;
          2:       nv = 0;
          default: nv = int'($urandom_range(0, 32768)) - 16384;
        endcase
        write_reg(CFG_NORMAL_X + CFG_IDX_W'(i), {noise[31:16], nv[15:0]});
      end
    end
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(5))
        0:       write_reg(CFG_PLANE_LIMIT, 32'h7FFF_FFFF);
        1:       write_reg(CFG_PLANE_LIMIT, 32'h8000_0000);
        2:       write_reg(CFG_PLANE_LIMIT, 32'h0);
        default: write_reg(CFG_PLANE_LIMIT, rand_coord(1'b1));
      endcase
    end
  endtask

  task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h got %h", $time, name, want, got);
      bad_results++;
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin
    clip_vtx_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_vertices.size() == 0) begin
        $display("%0t ns: result with no request pending, expected none got %h %h %h",
                 $time, res_if.out_x, res_if.out_y, res_if.out_z);
        bad_results++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("out_x", want.x, res_if.out_x);
        check_field("out_y", want.y, res_if.out_y);
        check_field("out_z", want.z, res_if.out_z);
        check_field("has_vertex", 32'(want.has_vertex), 32'(res_if.has_vertex));
        check_field("poly_done", 32'(want.done), 32'(res_if.poly_done));
        check_field("vertex_count", 32'(want.count), 32'(res_if.vertex_count));
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          items_rand;
    int          polys;
    int          n_verts;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    vtx_if.valid       = 1'b0;
    vtx_if.vertex_x    = '0;
    vtx_if.vertex_y    = '0;
    vtx_if.vertex_z    = '0;
    vtx_if.last_vertex = 1'b0;
    rst_ni             = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset plane is z <= 0: one-vertex polygons, extremes, point on the plane
    add_vtx(32'h0000_1000, 32'h0000_2000, 32'hFFFF_D000, 1'b1, 1,
            want_vtx(32'h0000_1000, 32'h0000_2000, 32'hFFFF_D000, 1'b1, 5'd1));
    add_vtx(32'h0000_5000, 32'h0000_5000, 32'h0000_1000, 1'b1, 1,
            want_vtx(32'h0, 32'h0, 32'h0, 1'b0, 5'd0));
    add_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1,
            want_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 5'd1));
    add_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1,
            want_vtx(32'h0, 32'h0, 32'h0, 1'b0, 5'd0));
    add_vtx(32'h0000_1000, 32'hFFFF_F000, 32'h0, 1'b1, 1,
            want_vtx(32'h0000_1000, 32'hFFFF_F000, 32'h0, 1'b1, 5'd1));
    // triangle with two crossings
    add_vtx(32'h0, 32'h0, 32'hFFFF_C000, 1'b0);
    add_vtx(32'h0000_4000, 32'h0, 32'h0000_4000, 1'b0);
    add_vtx(32'h0, 32'h0000_4000, 32'h0000_4000, 1'b1);
    // plane changed between vertices of one polygon
    add_vtx(32'hFFFF_F000, 32'h0, 32'hFFFF_F000, 1'b0);
    add_cfg(CFG_NORMAL_X, 32'h0000_4000);
    add_vtx(32'h0000_2000, 32'h0000_1000, 32'hFFFF_F000, 1'b0);
    add_vtx(32'hFFFF_E000, 32'h0000_3000, 32'h0000_5000, 1'b1);
    // extreme plane
    add_cfg(CFG_NORMAL_X, 32'hFFFF_C000);
    add_cfg(CFG_NORMAL_Y, 32'h0000_4000);
    add_cfg(CFG_NORMAL_Z, 32'h0);
    add_cfg(CFG_PLANE_LIMIT, 32'h7FFF_FFFF);
    add_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    add_vtx(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_vtx(32'h0, 32'h0, 32'h8000_0000, 1'b1);
    // out-of-range normal and an unused register index
    add_cfg(CFG_NORMAL_Z, 32'h0000_8000);
    add_cfg(CFG_UNUSED_IDX, 32'h1234_5678);
    add_cfg(CFG_PLANE_LIMIT, 32'h8000_0000);
    add_vtx(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000, 1'b0);
    add_vtx(32'hFFF8_0000, 32'h0004_0000, 32'hFFFD_0000, 1'b0);
    add_vtx(32'h7000_0000, 32'h9000_0000, 32'h0000_1000, 1'b0);
    add_vtx(32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0000, 1'b1);
    add_cfg(CFG_NORMAL_X, 32'h0);
    add_cfg(CFG_NORMAL_Y, 32'h0);
    add_cfg(CFG_NORMAL_Z, 32'(NORMAL_Z_RESET));
    add_cfg(CFG_PLANE_LIMIT, 32'h0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                    directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    items_rand = 0;
    polys      = 0;
    while (items_rand < RAND_ITEMS) begin
      if (tx_idle_pct == 33 && items_rand >= RAND_ITEMS / 3) begin
        tx_idle_pct = 76;
        rx_idle_pct = 33;
      end else if (tx_idle_pct == 76 && items_rand >= 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (polys > 0 && $urandom_range(4) == 0) rand_plane();
      if (polys == 0 || $urandom_range(19) == 0) begin
        // zig-zag across the plane, long enough to hit the output cap
        for (int i = 0; i < LONG_POLY; i++) begin
          for (int tries = 0; tries < 16; tries++) begin
            cx = rand_coord(1'b1);
            cy = rand_coord(1'b1);
            cz = rand_coord(1'b1);
            if ((plane_distance(to_pt(cx, cy, cz)) <= 0) == (i % 2 == 0)) break;
          end
          send_vertex(cx, cy, cz, i == LONG_POLY - 1, 0, '0);
        end
        items_rand += LONG_POLY;
      end else begin
        n_verts = $urandom_range(1, 7);
        for (int i = 0; i < n_verts; i++) begin
          send_vertex(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0),
                      i == n_verts - 1, 0, '0);
        end
        items_rand += n_verts;
      end
      polys++;
    end

    while (pending_vertices.size() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
    if (bad_results == 0 && pending_vertices.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_vertex_if.sv
hw/rtl/pcl_result_if.sv
hw/rtl/polygon_plane_clipper.sv
hw/rtl/pcl_checker.sv
tb/sv/tb_polygon_plane_clipper.sv
